[rtl/afsk_pkg.sv]
// ----------------------------------------------------------------------------
// afsk_pkg
// Shared types, codes and sine table helpers for the AFSK NRZI modulator.
// ----------------------------------------------------------------------------
package afsk_pkg;

    localparam int unsigned SINE_ENTRIES           = 512;
    localparam int unsigned SINE_AW                = 9;
    localparam int unsigned MAX_SAMPLES_PER_SYMBOL = 32;
    localparam int unsigned SAMP_CNT_W             = 5;

    // item kinds
    localparam logic [1:0] KIND_UNSTUFFED = 2'd0;
    localparam logic [1:0] KIND_STUFFED   = 2'd1;
    localparam logic [1:0] KIND_POSTAMBLE = 2'd2;
    localparam logic [1:0] KIND_UNUSED    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SAMPLES_PER_SYMBOL = 2'd0;
    localparam logic [1:0] CFG_LOW_TONE_STEP      = 2'd1;
    localparam logic [1:0] CFG_HIGH_TONE_STEP     = 2'd2;

    localparam logic [5:0]  RST_SAMPLES_PER_SYMBOL = 6'd32;
    localparam logic [15:0] RST_LOW_TONE_STEP      = 16'd2048;
    localparam logic [15:0] RST_HIGH_TONE_STEP     = 16'd3754;

    localparam logic [2:0] STUFF_RUN = 3'd5;
    localparam logic [2:0] ONES_MAX  = 3'd7;

    // x*13/10 as (x*MUL13_DIV10) >> 19, exact for multiples of 128 up to 2^14
    localparam logic [19:0] MUL13_DIV10 = 20'd681577;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam int unsigned TAYLOR_DIV [6] = '{6, 20, 42, 72, 110, 156};

    typedef struct packed {
        logic [1:0] kind;
        logic       bit_req;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_of_item;
    } t_out_item;

    typedef struct packed {
        logic vld;
        logic last;
    } t_samp_ctl;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_IDLE,
        ST_RUN
    } t_seq_state;

    typedef logic [30:0] t_qsine_tab [129];

    // sin(k*pi/256) in Q30, Taylor series to x^13
    function automatic logic [30:0] quarter_sine(input logic [7:0] k);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] sum;
        a    = ({56'd0, k} * PI_Q30) >> 8;
        a2   = (a * a) >> 30;
        term = a;
        sum  = a;
        for (int n = 1; n <= 6; n++) begin
            term = ((term * a2) >> 30) / TAYLOR_DIV[n-1];
            if ((n & 1) != 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum[30:0];
    endfunction

    function automatic t_qsine_tab build_qsine();
        t_qsine_tab t;
        for (int k = 0; k < 129; k++) begin
            t[k] = quarter_sine(8'(k));
        end
        return t;
    endfunction

    localparam t_qsine_tab QSINE = build_qsine();

    // full-period unsigned 8-bit sine entry, mirrored from the quarter wave
    function automatic logic [7:0] sine_entry(input logic [SINE_AW-1:0] idx);
        logic [1:0]  q;
        logic [7:0]  r;
        logic [7:0]  k;
        logic [30:0] s;
        logic [39:0] p;
        logic [39:0] v;
        q = idx[8:7];
        r = {1'b0, idx[6:0]};
        k = q[0] ? (8'd128 - r) : r;
        s = QSINE[k];
        p = {1'b0, s, 8'd0} - {9'd0, s};
        v = q[1] ? (40'h40_0000_0000 - p) : (40'h40_0000_0000 + p);
        return (v[39:31] > 9'd255) ? 8'd255 : v[38:31];
    endfunction

endpackage

[rtl/afsk_ram.sv]
// ----------------------------------------------------------------------------
// afsk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module afsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/afsk_seq.sv]
// ----------------------------------------------------------------------------
// afsk_seq
// Symbol sequencer: sine memory load, NRZI/stuffing state, phase accumulator.
// ----------------------------------------------------------------------------
module afsk_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_in_valid,
    input  afsk_pkg::t_in_item           i_in_item,
    output logic                         o_in_stall,
    input  logic [5:0]                   i_samples_per_symbol,
    input  logic [15:0]                  i_low_tone_step,
    input  logic [15:0]                  i_high_tone_step,
    output logic                         o_ram_we,
    output logic [afsk_pkg::SINE_AW-1:0] o_ram_waddr,
    output logic [7:0]                   o_ram_wdata,
    output logic [afsk_pkg::SINE_AW-1:0] o_ram_raddr,
    output afsk_pkg::t_samp_ctl          o_ctl
);
    import afsk_pkg::*;

    t_seq_state             r_state, n_state;
    logic [SINE_AW-1:0]     r_fill_addr, n_fill_addr;
    logic [15:0]            r_phase, n_phase;
    logic                   r_tone, n_tone;
    logic [2:0]             r_ones, n_ones;
    logic                   r_cur_tone, n_cur_tone;
    logic                   r_next_tone, n_next_tone;
    logic                   r_two, n_two;
    logic [SAMP_CNT_W-1:0]  r_samp, n_samp;

    logic                   accept;
    logic [SAMP_CNT_W-1:0]  sps_m1;
    logic                   stuff;
    logic                   t1, t2;
    logic [2:0]             o1, o2;
    logic                   sym_end;

    assign accept = i_in_valid && !o_in_stall;

    // samples per symbol minus one, with 0 treated as 1 and overflow clamped
    always_comb begin
        if (i_samples_per_symbol == 6'd0) begin
            sps_m1 = '0;
        end else if (i_samples_per_symbol > 6'(MAX_SAMPLES_PER_SYMBOL)) begin
            sps_m1 = SAMP_CNT_W'(MAX_SAMPLES_PER_SYMBOL - 1);
        end else begin
            sps_m1 = SAMP_CNT_W'(i_samples_per_symbol - 6'd1);
        end
    end

    // NRZI and stuffing decisions for the offered item
    always_comb begin
        stuff = (i_in_item.kind == KIND_STUFFED) && (r_ones >= STUFF_RUN);
        t1    = stuff ? !r_tone : r_tone;
        o1    = (stuff || (i_in_item.kind == KIND_UNSTUFFED)) ? 3'd0 : r_ones;
        if (i_in_item.bit_req) begin
            t2 = t1;
            o2 = (o1 == ONES_MAX) ? ONES_MAX : o1 + 3'd1;
        end else begin
            t2 = !t1;
            o2 = 3'd0;
        end
    end

    assign sym_end = (r_samp == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_FILL: begin
                if (r_fill_addr == SINE_AW'(SINE_ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && (i_in_item.kind != KIND_UNUSED)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_en && sym_end && !r_two) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_fill_addr = r_fill_addr;
        n_phase     = r_phase;
        n_tone      = r_tone;
        n_ones      = r_ones;
        n_cur_tone  = r_cur_tone;
        n_next_tone = r_next_tone;
        n_two       = r_two;
        n_samp      = r_samp;
        o_ram_we    = 1'b0;
        o_ctl       = '0;
        o_in_stall  = 1'b1;
        case (r_state)
            ST_FILL: begin
                o_ram_we    = 1'b1;
                n_fill_addr = r_fill_addr + 1'b1;
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (accept) begin
                    n_samp = sps_m1;
                    case (i_in_item.kind)
                        KIND_POSTAMBLE: begin
                            n_cur_tone = 1'b0;
                            n_two      = 1'b0;
                        end
                        KIND_UNSTUFFED, KIND_STUFFED: begin
                            n_tone      = t2;
                            n_ones      = o2;
                            n_cur_tone  = stuff ? t1 : t2;
                            n_next_tone = t2;
                            n_two       = stuff;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                o_ctl.vld  = 1'b1;
                o_ctl.last = sym_end && !r_two;
                if (i_en) begin
                    n_phase = r_phase + (r_cur_tone ? i_high_tone_step : i_low_tone_step);
                    if (sym_end) begin
                        n_samp     = sps_m1;
                        n_two      = 1'b0;
                        n_cur_tone = r_next_tone;
                    end else begin
                        n_samp = r_samp - 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_ram_waddr = r_fill_addr;
    assign o_ram_wdata = sine_entry(r_fill_addr);
    assign o_ram_raddr = r_phase[15:7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_fill_addr <= '0;
            r_phase     <= '0;
            r_tone      <= 1'b0;
            r_ones      <= '0;
            r_two       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill_addr <= n_fill_addr;
            r_phase     <= n_phase;
            r_tone      <= n_tone;
            r_ones      <= n_ones;
            r_two       <= n_two;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_tone  <= n_cur_tone;
        r_next_tone <= n_next_tone;
        r_samp      <= n_samp;
    end
endmodule

[rtl/afsk_scale.sv]
// ----------------------------------------------------------------------------
// afsk_scale
// Sample pipeline: sine data to signed sample scaled by 1.3, output register.
// ----------------------------------------------------------------------------
module afsk_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  afsk_pkg::t_samp_ctl i_ctl,
    input  logic [7:0]          i_rom_data,
    output logic                o_en,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output afsk_pkg::t_out_item o_out_item
);
    import afsk_pkg::*;

    t_samp_ctl    r_s1_ctl;
    t_samp_ctl    r_p_ctl;
    logic         r_p_neg;
    logic [27:0]  r_p_prod;
    logic         r_o_vld;
    t_out_item    r_o_item;

    logic         neg;
    logic [7:0]   magd;
    logic [14:0]  scaled;
    logic [15:0]  smp;

    // whole pipeline freezes while a finished sample is held off
    assign o_en = !r_o_vld || !i_out_stall;

    // |rom*128 - 16384| = |rom - 128| << 7; the << 7 is folded into the shift
    assign neg  = !i_rom_data[7];
    assign magd = neg ? (8'd128 - i_rom_data) : (i_rom_data - 8'd128);

    assign scaled = r_p_prod[26:12];
    assign smp    = r_p_neg ? (16'd0 - {1'b0, scaled}) : {1'b0, scaled};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_p_ctl  <= '0;
            r_o_vld  <= 1'b0;
        end else if (o_en) begin
            r_s1_ctl <= i_ctl;
            r_p_ctl  <= r_s1_ctl;
            r_o_vld  <= r_p_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_p_neg               <= neg;
            r_p_prod              <= 28'(magd) * 28'(MUL13_DIV10);
            r_o_item.sample       <= smp;
            r_o_item.last_of_item <= r_p_ctl.last;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_out_item  = r_o_item;
endmodule

[rtl/afsk_nrzi_bitstuff_modulator_unit.sv]
// ----------------------------------------------------------------------------
// afsk_nrzi_bitstuff_modulator_unit
// AFSK tone modulator with NRZI coding and HDLC bit stuffing.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake               | Payload
//  in      | to block  | i_in_valid / o_in_stall | i_in_item  (kind, bit_req)
//  out     | from block| o_out_valid/ i_out_stall| o_out_item (sample, last_of_item)
//  cfg     | to block  | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
//  One sample per cycle from the sine memory read port while an item runs and
//  the output is not stalled; an item takes samples_per_symbol samples (twice
//  that with an inserted stuff symbol) and the sequencer idles between items.
//  After reset the whole sine memory is loaded with the input stalled.
//  An output stall freezes the whole sample pipeline and the phase accumulator.
// ----------------------------------------------------------------------------
module afsk_nrzi_bitstuff_modulator_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  afsk_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output afsk_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import afsk_pkg::*;

    logic [5:0]          r_samples_per_symbol;
    logic [15:0]         r_low_tone_step;
    logic [15:0]         r_high_tone_step;

    logic                en;
    logic                ram_we;
    logic [SINE_AW-1:0]  ram_waddr;
    logic [7:0]          ram_wdata;
    logic [SINE_AW-1:0]  ram_raddr;
    logic [7:0]          ram_rdata;
    t_samp_ctl           ctl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples_per_symbol <= RST_SAMPLES_PER_SYMBOL;
            r_low_tone_step      <= RST_LOW_TONE_STEP;
            r_high_tone_step     <= RST_HIGH_TONE_STEP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SAMPLES_PER_SYMBOL: r_samples_per_symbol <= i_cfg_data[5:0];
                CFG_LOW_TONE_STEP:      r_low_tone_step      <= i_cfg_data;
                CFG_HIGH_TONE_STEP:     r_high_tone_step     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    afsk_seq u_seq (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_en                 (en),
        .i_in_valid           (i_in_valid),
        .i_in_item            (i_in_item),
        .o_in_stall           (o_in_stall),
        .i_samples_per_symbol (r_samples_per_symbol),
        .i_low_tone_step      (r_low_tone_step),
        .i_high_tone_step     (r_high_tone_step),
        .o_ram_we             (ram_we),
        .o_ram_waddr          (ram_waddr),
        .o_ram_wdata          (ram_wdata),
        .o_ram_raddr          (ram_raddr),
        .o_ctl                (ctl)
    );

    afsk_ram #(
        .WIDTH (8),
        .DEPTH (SINE_ENTRIES)
    ) u_sine_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (en),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    afsk_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_rom_data  (ram_rdata),
        .o_en        (en),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );
endmodule

[rtl/afsk_chk.sv]
// ----------------------------------------------------------------------------
// afsk_chk
// Port-level checks for the AFSK modulator, bound to the top level.
// ----------------------------------------------------------------------------
module afsk_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input afsk_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input afsk_pkg::t_out_item o_out_item
);
    import afsk_pkg::*;

    // a held sample stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed while stalled");

    // sine memory load keeps the input closed right after reset
    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input open right after reset");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // an unused kind is dropped and the input stays open
    a_unused_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.kind == KIND_UNUSED) |=> !o_in_stall)
        else $error("unused kind item was not dropped");

    // a real item occupies the sequencer
    a_item_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.kind != KIND_UNUSED) |=> o_in_stall)
        else $error("input not stalled while emitting an item");
endmodule

bind afsk_nrzi_bitstuff_modulator_unit afsk_chk u_afsk_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
